// ===== sv/ile_pkg.sv =====
// Package for the indexed list engine: action and status codes, field widths
// and stream packing widths. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

    localparam int ActionW = 3;
    localparam int PosW    = 6;
    localparam int DataW   = 32;
    localparam int StatusW = 2;
    localparam int CountW  = 7;

    localparam int InBitsW  = ActionW + PosW + DataW;
    localparam int OutBitsW = DataW + StatusW + CountW;
    localparam int InTdataW  = ((InBitsW + 7) / 8) * 8;
    localparam int OutTdataW = ((OutBitsW + 7) / 8) * 8;

    localparam logic [ActionW-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ActionW-1:0] ACT_INSERT    = 3'd1;
    localparam logic [ActionW-1:0] ACT_OVERWRITE = 3'd2;
    localparam logic [ActionW-1:0] ACT_REMOVE    = 3'd3;
    localparam logic [ActionW-1:0] ACT_READ      = 3'd4;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

endpackage

`default_nettype wire

// ===== sv/ile_store.sv =====
// Entry store of the indexed list engine: one write port and one read port
// with registered read data. It uses ile_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module ile_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire                          clk,
    input  wire                          we,
    input  wire [AW-1:0]                 waddr,
    input  wire [ile_pkg::DataW-1:0]     wdata,
    input  wire [AW-1:0]                 raddr,
    output logic [ile_pkg::DataW-1:0]    rdata
);

    logic [ile_pkg::DataW-1:0] mem [DEPTH];
    logic [ile_pkg::DataW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/indexed_list_engine_top.sv =====
// Top level of the indexed list engine: request decode, shift sequencer and
// result register. It uses ile_pkg and the entry store ile_store.
//
// Channel   Direction  Contents
// s_*       in         request item: action, position, value
// m_*       out        result item: read_value, status, count
//
// Append, overwrite, rejected requests, unused actions, an insert at the end
// and a remove of the last entry finish in S_IDLE; a read passes S_READ_WAIT.
// Any other insert goes through S_SHIFT, S_FLUSH and S_FILL, and any other
// remove through S_SHIFT and S_FLUSH, as the store moves one entry per cycle.
// After reset the list is empty. A result waits in the output register
// while m_tready is low, and the next request is taken once it leaves.
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine_top #(
    parameter int CAPACITY = 64
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // action [2:0], position [8:3], value [40:9], zero fill above
    input  wire [ile_pkg::InTdataW-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // read_value [31:0], status [33:32], count [40:34], zero fill above
    output logic [ile_pkg::OutTdataW-1:0]     m_tdata
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ile_pkg::PosW) ? CW : ile_pkg::PosW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_FLUSH,
        S_FILL,
        S_READ_WAIT
    } state_t;

    state_t                        state_reg;
    logic [CW-1:0]                 count_reg;
    logic [AW-1:0]                 rd_ptr_reg;
    logic [AW-1:0]                 stop_reg;
    logic [AW-1:0]                 wr_addr_reg;
    logic [AW-1:0]                 pos_reg;
    logic [ile_pkg::DataW-1:0]     value_reg;
    logic                          pend_reg;
    logic                          up_reg;
    logic                          m_tvalid_reg;
    logic [ile_pkg::DataW-1:0]     rv_reg;
    logic [ile_pkg::StatusW-1:0]   st_reg;
    logic [ile_pkg::CountW-1:0]    cnt_out_reg;

    logic [ile_pkg::ActionW-1:0]   in_action;
    logic [ile_pkg::PosW-1:0]      in_pos;
    logic [ile_pkg::DataW-1:0]     in_value;
    logic                          s_accept;
    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               cnt_ext;
    logic                          full;
    logic                          pos_lt_cnt;
    logic                          pos_eq_cnt;
    logic [AW-1:0]                 pos_addr;
    logic [AW-1:0]                 cnt_addr;

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [ile_pkg::DataW-1:0]     mem_wdata;
    logic [AW-1:0]                 mem_raddr;
    logic [ile_pkg::DataW-1:0]     mem_rdata;

    assign in_action = s_tdata[ile_pkg::ActionW-1:0];
    assign in_pos    = s_tdata[ile_pkg::ActionW +: ile_pkg::PosW];
    assign in_value  = s_tdata[ile_pkg::ActionW + ile_pkg::PosW +: ile_pkg::DataW];

    assign s_tready = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;

    assign pos_ext    = CMPW'(in_pos);
    assign cnt_ext    = CMPW'(count_reg);
    assign full       = (count_reg == CW'(CAPACITY));
    assign pos_lt_cnt = (pos_ext < cnt_ext);
    assign pos_eq_cnt = (pos_ext == cnt_ext);
    assign pos_addr   = AW'(in_pos);
    assign cnt_addr   = AW'(count_reg);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = mem_rdata;
        mem_raddr = rd_ptr_reg;
        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = pos_addr;
                mem_wdata = in_value;
                if (s_accept)
                begin
                    case (in_action)
                        ile_pkg::ACT_APPEND:
                        begin
                            mem_we    = !full;
                            mem_waddr = cnt_addr;
                        end
                        ile_pkg::ACT_INSERT:
                        begin
                            mem_we    = pos_eq_cnt && !full;
                            mem_waddr = cnt_addr;
                        end
                        ile_pkg::ACT_OVERWRITE:
                        begin
                            mem_we    = pos_lt_cnt;
                            mem_waddr = pos_addr;
                        end
                        default:
                        begin
                            mem_we = 1'b0;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                mem_we = pend_reg;
            end
            S_FLUSH:
            begin
                mem_we = 1'b1;
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = value_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    ile_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            up_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            rd_ptr_reg   <= '0;
            stop_reg     <= '0;
            wr_addr_reg  <= '0;
            pos_reg      <= '0;
            value_reg    <= '0;
            rv_reg       <= '0;
            st_reg       <= ile_pkg::ST_OK;
            cnt_out_reg  <= '0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        rv_reg       <= '0;
                        st_reg       <= ile_pkg::ST_OK;
                        cnt_out_reg  <= ile_pkg::CountW'(count_reg);
                        m_tvalid_reg <= 1'b1;
                        pos_reg      <= pos_addr;
                        value_reg    <= in_value;
                        pend_reg     <= 1'b0;
                        case (in_action)
                            ile_pkg::ACT_APPEND:
                            begin
                                if (full)
                                begin
                                    st_reg <= ile_pkg::ST_FULL;
                                end
                                else
                                begin
                                    count_reg   <= count_reg + 1'b1;
                                    cnt_out_reg <= ile_pkg::CountW'(count_reg + 1'b1);
                                end
                            end
                            ile_pkg::ACT_INSERT:
                            begin
                                if (!pos_lt_cnt && !pos_eq_cnt)
                                begin
                                    st_reg <= ile_pkg::ST_BAD_INDEX;
                                end
                                else if (full)
                                begin
                                    st_reg <= ile_pkg::ST_FULL;
                                end
                                else if (pos_eq_cnt)
                                begin
                                    count_reg   <= count_reg + 1'b1;
                                    cnt_out_reg <= ile_pkg::CountW'(count_reg + 1'b1);
                                end
                                else
                                begin
                                    m_tvalid_reg <= 1'b0;
                                    up_reg       <= 1'b1;
                                    rd_ptr_reg   <= cnt_addr - 1'b1;
                                    stop_reg     <= pos_addr;
                                    state_reg    <= S_SHIFT;
                                end
                            end
                            ile_pkg::ACT_OVERWRITE:
                            begin
                                if (!pos_lt_cnt)
                                begin
                                    st_reg <= ile_pkg::ST_BAD_INDEX;
                                end
                            end
                            ile_pkg::ACT_REMOVE:
                            begin
                                if (!pos_lt_cnt)
                                begin
                                    st_reg <= ile_pkg::ST_BAD_INDEX;
                                end
                                else if (pos_ext + 1'b1 == cnt_ext)
                                begin
                                    count_reg   <= count_reg - 1'b1;
                                    cnt_out_reg <= ile_pkg::CountW'(count_reg - 1'b1);
                                end
                                else
                                begin
                                    m_tvalid_reg <= 1'b0;
                                    up_reg       <= 1'b0;
                                    rd_ptr_reg   <= pos_addr + 1'b1;
                                    stop_reg     <= cnt_addr - 1'b1;
                                    state_reg    <= S_SHIFT;
                                end
                            end
                            ile_pkg::ACT_READ:
                            begin
                                if (!pos_lt_cnt)
                                begin
                                    st_reg <= ile_pkg::ST_BAD_INDEX;
                                end
                                else
                                begin
                                    m_tvalid_reg <= 1'b0;
                                    state_reg    <= S_READ_WAIT;
                                end
                            end
                            default:
                            begin
                                st_reg <= ile_pkg::ST_OK;
                            end
                        endcase
                    end
                end
                S_SHIFT:
                begin
                    pend_reg    <= 1'b1;
                    wr_addr_reg <= up_reg ? rd_ptr_reg + 1'b1 : rd_ptr_reg - 1'b1;
                    if (rd_ptr_reg == stop_reg)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else
                    begin
                        rd_ptr_reg <= up_reg ? rd_ptr_reg - 1'b1 : rd_ptr_reg + 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    pend_reg <= 1'b0;
                    if (up_reg)
                    begin
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        count_reg    <= count_reg - 1'b1;
                        cnt_out_reg  <= ile_pkg::CountW'(count_reg - 1'b1);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_FILL:
                begin
                    count_reg    <= count_reg + 1'b1;
                    cnt_out_reg  <= ile_pkg::CountW'(count_reg + 1'b1);
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                S_READ_WAIT:
                begin
                    rv_reg       <= mem_rdata;
                    m_tvalid_reg <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = ile_pkg::OutTdataW'({cnt_out_reg, st_reg, rv_reg});

    // The live count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The store is written while idle only for a request taken in that cycle.
    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && mem_we |-> s_accept)
        else $error("store written while idle without a request");

    // A full status is reported only with a full list.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg && (st_reg == ile_pkg::ST_FULL)
        |-> cnt_out_reg == ile_pkg::CountW'(CAPACITY))
        else $error("full status with room left");

    // No result is shown while a shift or fill is under way.
    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) || (state_reg == S_FILL) |-> !m_tvalid_reg)
        else $error("result shown during a shift");

    // Shift reads stay inside the used part of the list.
    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> CW'(rd_ptr_reg) < count_reg)
        else $error("shift read beyond the list");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for indexed_list_engine_top: drives list requests on the
// input stream and checks every result against an in-bench model of the list.
// It depends on ile_pkg and indexed_list_engine_top.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    localparam int ListCapacity = 64;
    localparam int StallLimit   = 2000;
    localparam int HoldCycles   = 300;
    localparam int SettleCycles = 100;

    typedef struct {
        logic [ile_pkg::ActionW-1:0]      action;
        logic [ile_pkg::PosW-1:0]         position;
        logic signed [ile_pkg::DataW-1:0] value;
    } list_req_t;

    typedef struct {
        logic signed [ile_pkg::DataW-1:0] read_value;
        logic [ile_pkg::StatusW-1:0]      status;
        logic [ile_pkg::CountW-1:0]       count;
    } list_resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [ile_pkg::InTdataW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [ile_pkg::OutTdataW-1:0] m_tdata;

    list_req_t  request_queue[$];
    list_resp_t expected_results[$];

    logic [ile_pkg::DataW-1:0] list_entries[ListCapacity];
    int list_length = 0;
    int gen_length = 0;
    bit filling = 1'b1;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    int failures = 0;
    int requests_taken = 0;
    int results_checked = 0;
    int full_rejects = 0;
    int index_rejects = 0;
    int peak_length = 0;
    int quiet_cycles = 0;

    list_req_t offered_req;

    indexed_list_engine_top #(
        .CAPACITY (ListCapacity)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic list_resp_t apply_list_request(list_req_t req);
        list_resp_t resp;
        int i;
        resp.read_value = '0;
        resp.status = ile_pkg::ST_OK;
        case (req.action)
            ile_pkg::ACT_APPEND:
                if (list_length >= ListCapacity)
                    resp.status = ile_pkg::ST_FULL;
                else
                begin
                    list_entries[list_length] = req.value;
                    list_length++;
                end
            ile_pkg::ACT_INSERT:
                if (req.position > list_length)
                    resp.status = ile_pkg::ST_BAD_INDEX;
                else if (list_length >= ListCapacity)
                    resp.status = ile_pkg::ST_FULL;
                else
                begin
                    for (i = list_length; i > req.position; i--)
                        list_entries[i] = list_entries[i - 1];
                    list_entries[req.position] = req.value;
                    list_length++;
                end
            ile_pkg::ACT_OVERWRITE:
                if (req.position >= list_length)
                    resp.status = ile_pkg::ST_BAD_INDEX;
                else
                    list_entries[req.position] = req.value;
            ile_pkg::ACT_REMOVE:
                if (req.position >= list_length)
                    resp.status = ile_pkg::ST_BAD_INDEX;
                else
                begin
                    for (i = req.position; i + 1 < list_length; i++)
                        list_entries[i] = list_entries[i + 1];
                    list_length--;
                end
            ile_pkg::ACT_READ:
                if (req.position >= list_length)
                    resp.status = ile_pkg::ST_BAD_INDEX;
                else
                    resp.read_value = list_entries[req.position];
            default:
                ;
        endcase
        resp.count = ile_pkg::CountW'(list_length);
        if (resp.status == ile_pkg::ST_FULL)
            full_rejects++;
        if (resp.status == ile_pkg::ST_BAD_INDEX)
            index_rejects++;
        if (list_length > peak_length)
            peak_length = list_length;
        return resp;
    endfunction

    task automatic queue_request(logic [ile_pkg::ActionW-1:0] action,
                                 logic [ile_pkg::PosW-1:0] position,
                                 logic [ile_pkg::DataW-1:0] value);
        list_req_t req;
        req.action = action;
        req.position = position;
        req.value = value;
        request_queue.push_back(req);
        case (action)
            ile_pkg::ACT_APPEND:
                if (gen_length < ListCapacity)
                    gen_length++;
            ile_pkg::ACT_INSERT:
                if (position <= gen_length && gen_length < ListCapacity)
                    gen_length++;
            ile_pkg::ACT_REMOVE:
                if (position < gen_length)
                    gen_length--;
            default:
                ;
        endcase
    endtask

    task automatic queue_random_requests(int n);
        int k;
        int r;
        int top;
        logic [ile_pkg::ActionW-1:0] act;
        logic [ile_pkg::PosW-1:0] pos;
        logic [ile_pkg::DataW-1:0] val;
        for (k = 0; k < n; k++)
        begin
            if (gen_length == ListCapacity && $urandom_range(0, 5) == 0)
                filling = 1'b0;
            else if (gen_length <= 2)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (r < 4)
                act = ile_pkg::ACT_READ + ile_pkg::ActionW'($urandom_range(1, 3));
            else if (r < (filling ? 34 : 14))
                act = ile_pkg::ACT_APPEND;
            else if (r < (filling ? 58 : 26))
                act = ile_pkg::ACT_INSERT;
            else if (r < (filling ? 70 : 44))
                act = ile_pkg::ACT_OVERWRITE;
            else if (r < (filling ? 80 : 78))
                act = ile_pkg::ACT_REMOVE;
            else
                act = ile_pkg::ACT_READ;
            if (gen_length == 0 || $urandom_range(0, 9) == 0)
                pos = ile_pkg::PosW'($urandom_range(0, 63));
            else if (act == ile_pkg::ACT_INSERT)
            begin
                top = (gen_length > 63) ? 63 : gen_length;
                pos = ile_pkg::PosW'($urandom_range(0, top));
            end
            else
                pos = ile_pkg::PosW'($urandom_range(0, gen_length - 1));
            if ($urandom_range(0, 9) == 0)
                case ($urandom_range(0, 3))
                    0: val = 32'h8000_0000;
                    1: val = 32'h7FFF_FFFF;
                    2: val = '0;
                    default: val = '1;
                endcase
            else
                val = $urandom;
            queue_request(act, pos, val);
        end
    endtask

    task automatic wait_for_drain();
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        list_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_list_request(offered_req));
                requests_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    nxt = request_queue.pop_front();
                    offered_req = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(ile_pkg::InTdataW - ile_pkg::InBitsW){1'b0}}, nxt.value,
                                nxt.position, nxt.action};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            m_tready <= 1'b0;
            hold_left <= HoldCycles;
            hold_served <= hold_served + 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin : result_monitor
        list_resp_t want;
        logic signed [ile_pkg::DataW-1:0] got_value;
        logic [ile_pkg::StatusW-1:0] got_status;
        logic [ile_pkg::CountW-1:0] got_count;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_value = m_tdata[ile_pkg::DataW-1:0];
            got_status = m_tdata[ile_pkg::DataW +: ile_pkg::StatusW];
            got_count = m_tdata[ile_pkg::DataW + ile_pkg::StatusW +: ile_pkg::CountW];
            if (expected_results.size() == 0)
            begin
                $error("result with no request waiting: read_value %0d status %0d count %0d",
                       got_value, got_status, got_count);
                failures++;
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got_value !== want.read_value)
                begin
                    $error("read_value: expected %0d, got %0d", want.read_value, got_value);
                    failures++;
                end
                if (got_status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    failures++;
                end
                if (got_count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, got_count);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= StallLimit)
        begin
            $display("Timeout: no item accepted for %0d cycles", StallLimit);
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        tx_idle_pct = 10;
        rx_idle_pct = 76;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Start empty with out-of-range requests, then build, read and empty a short list.
        queue_request(ile_pkg::ACT_READ, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_OVERWRITE, 6'd0, 32'h5555_5555);
        queue_request(ile_pkg::ACT_INSERT, 6'd1, 32'h1111_1111);
        queue_request(ile_pkg::ACT_INSERT, 6'd0, 32'h7FFF_FFFF);
        queue_request(ile_pkg::ACT_APPEND, 6'd63, 32'h8000_0000);
        queue_request(ile_pkg::ACT_INSERT, 6'd2, 32'hFFFF_FFFF);
        queue_request(ile_pkg::ACT_INSERT, 6'd1, 32'h0000_0000);
        queue_request(ile_pkg::ACT_OVERWRITE, 6'd3, 32'h1234_5678);
        queue_request(ile_pkg::ACT_READ, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd1, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd2, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd3, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd4, 32'd0);
        queue_request(ile_pkg::ACT_INSERT, 6'd5, 32'hDEAD_BEEF);
        queue_request(ile_pkg::ACT_REMOVE, 6'd1, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd2, 32'd0);
        queue_request(ile_pkg::ACT_READ + 3'd1, 6'd63, 32'hFFFF_FFFF);
        queue_request(ile_pkg::ACT_READ + 3'd2, 6'd63, 32'hFFFF_FFFF);
        queue_request(ile_pkg::ACT_READ + 3'd3, 6'd63, 32'hFFFF_FFFF);
        queue_request(ile_pkg::ACT_READ, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd1, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_READ, 6'd0, 32'd0);

        // Fill to capacity, then hit the full list from every side.
        while (gen_length < ListCapacity)
            queue_request(ile_pkg::ACT_APPEND, ile_pkg::PosW'($urandom), $urandom);
        queue_request(ile_pkg::ACT_APPEND, 6'd0, 32'h0BAD_0BAD);
        queue_request(ile_pkg::ACT_INSERT, 6'd0, 32'h0BAD_0BAD);
        queue_request(ile_pkg::ACT_INSERT, 6'd63, 32'h0BAD_0BAD);
        queue_request(ile_pkg::ACT_READ, 6'd63, 32'd0);
        queue_request(ile_pkg::ACT_OVERWRITE, 6'd63, 32'h8000_0000);
        queue_request(ile_pkg::ACT_READ, 6'd63, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd0, 32'd0);
        queue_request(ile_pkg::ACT_INSERT, 6'd63, 32'h7FFF_FFFF);
        queue_request(ile_pkg::ACT_READ, 6'd63, 32'd0);
        queue_request(ile_pkg::ACT_REMOVE, 6'd63, 32'd0);
        queue_request(ile_pkg::ACT_INSERT, 6'd0, 32'hFFFF_FFFF);
        queue_request(ile_pkg::ACT_READ, 6'd0, 32'd0);

        queue_random_requests(180);
        wait_for_drain();

        tx_idle_pct = 76;
        rx_idle_pct = 10;
        queue_random_requests(180);
        wait_for_drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests = hold_requests + 1;
        queue_random_requests(150);
        wait_for_drain();

        repeat (SettleCycles) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            failures++;
        end
        $display("Checked %0d results for %0d requests; %0d rejected as full, %0d as bad index.",
                 results_checked, requests_taken, full_rejects, index_rejects);
        $display("The list reached %0d entries under random and long output stalls.",
                 peak_length);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
sv/ile_pkg.sv
sv/ile_store.sv
sv/indexed_list_engine_top.sv
tb/sv/testbench.sv
